### hdl/lcp_pkg.sv
// Shared widths, types and codes for the line-to-line closest point pipeline.
package lcp_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int FB    = 16;            // fraction bits of a coordinate
    localparam int EPS_W = 63;
    localparam int GAP_W = 64;

    localparam int WW   = CW + 1;         // origin difference
    localparam int DPW  = 2 * CW + 1;     // one term of a dot product
    localparam int DW   = 2 * CW + 3;     // dot product
    localparam int LW   = (DW + 1) / 2;   // low half of a dot product
    localparam int HW   = DW - LW;        // high half of a dot product
    localparam int PW   = 2 * DW;         // product of two dot products
    localparam int CKW  = (PW + 3) / 4;   // low chunk of a numerator
    localparam int TW   = PW - 3 * CKW;   // top chunk of a numerator
    localparam int SW   = 2 * CKW + CW + 2;
    localparam int MW   = PW + CW;        // scaled numerator
    localparam int RW   = MW + 2;         // divider compare width
    localparam int QB   = CW + 2;         // quotient bits before saturation
    localparam int QW   = QB + 2;         // signed rounded quotient
    localparam int SQ_W = 2 * WW;

    localparam int COEF_LAT = 8;
    localparam int DIV_LAT  = QB + 6;

    typedef enum logic [1:0] {
        ST_GENERAL  = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_DEGEN    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [WW-1:0] x;
        logic signed [WW-1:0] y;
        logic signed [WW-1:0] z;
    } t_wvec;

    typedef struct packed {
        logic par;
        logic degen;
    } t_case;

endpackage

### hdl/lcp_if.sv
// Query and result channel interfaces.
interface lcp_in_if import lcp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_a_x;
    logic signed [CW-1:0] origin_a_y;
    logic signed [CW-1:0] origin_a_z;
    logic signed [CW-1:0] dir_a_x;
    logic signed [CW-1:0] dir_a_y;
    logic signed [CW-1:0] dir_a_z;
    logic signed [CW-1:0] origin_b_x;
    logic signed [CW-1:0] origin_b_y;
    logic signed [CW-1:0] origin_b_z;
    logic signed [CW-1:0] dir_b_x;
    logic signed [CW-1:0] dir_b_y;
    logic signed [CW-1:0] dir_b_z;

    modport source (
        output valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y, dir_a_z,
        output origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
        input  ready
    );
    modport sink (
        input  valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y, dir_a_z,
        input  origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
        output ready
    );
endinterface

interface lcp_out_if import lcp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] near_a_x;
    logic signed [CW-1:0] near_a_y;
    logic signed [CW-1:0] near_a_z;
    logic signed [CW-1:0] near_b_x;
    logic signed [CW-1:0] near_b_y;
    logic signed [CW-1:0] near_b_z;
    logic [GAP_W-1:0]     gap_squared;
    logic [1:0]           status;

    modport source (
        output valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z,
        output gap_squared, status,
        input  ready
    );
    modport sink (
        input  valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z,
        input  gap_squared, status,
        output ready
    );
endinterface

### hdl/lcp_wmul.sv
// Three-stage signed multiplier for two dot products, built from half-width partials.
module lcp_wmul import lcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [PW-1:0] o_p
);

    logic signed [HW-1:0]      a_hi, b_hi;
    logic signed [LW:0]        a_lo, b_lo;
    logic signed [2*HW-1:0]    r_hh;
    logic signed [HW+LW:0]     r_hl, r_lh;
    logic [2*LW-1:0]           r_ll;
    logic signed [HW+LW+1:0]   r_mid;
    logic [PW-1:0]             r_cat;
    logic signed [PW-1:0]      r_p;

    assign a_hi = i_a[DW-1:LW];
    assign b_hi = i_b[DW-1:LW];
    assign a_lo = $signed({1'b0, i_a[LW-1:0]});
    assign b_lo = $signed({1'b0, i_b[LW-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh  <= a_hi * b_hi;
            r_hl  <= a_hi * b_lo;
            r_lh  <= a_lo * b_hi;
            r_ll  <= i_a[LW-1:0] * i_b[LW-1:0];
            // The low product is unsigned and never reaches the high product's bits.
            r_mid <= (HW+LW+2)'(r_hl) + (HW+LW+2)'(r_lh);
            r_cat <= {r_hh, r_ll};
            r_p   <= $signed(r_cat) + (PW'(r_mid) <<< LW);
        end
    end

    assign o_p = r_p;

endmodule

### hdl/lcp_coef.sv
// Dot products, the determinant and both numerators, and the parallel decision.
module lcp_coef import lcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [EPS_W-1:0]     i_eps,
    input  t_vec                 i_da,
    input  t_vec                 i_db,
    input  t_wvec                i_w,
    output logic signed [PW-1:0] o_num_a,
    output logic signed [PW-1:0] o_den_a,
    output logic signed [PW-1:0] o_num_b,
    output logic signed [PW-1:0] o_den_b,
    output t_case                o_case
);

    logic signed [CW-1:0]  da [3];
    logic signed [CW-1:0]  db [3];
    logic signed [WW-1:0]  w  [3];
    logic signed [DPW-1:0] r_aa [3];
    logic signed [DPW-1:0] r_ee [3];
    logic signed [DPW-1:0] r_ab [3];
    logic signed [DPW-1:0] r_aw [3];
    logic signed [DPW-1:0] r_bw [3];
    logic signed [DW-1:0]  r_a, r_e, r_b, r_c, r_f;
    logic signed [PW-1:0]  p_ae, p_bb, p_bf, p_ec, p_af, p_bc;
    logic signed [DW-1:0]  r_e_dly [5];
    logic signed [DW-1:0]  r_f_dly [5];
    logic signed [PW-1:0]  r_dd, r_sn, r_tn;
    logic signed [PW-1:0]  r_dd7, r_sn7, r_tn7;
    logic [PW-1:0]         r_absd;
    logic signed [PW-1:0]  r_num_a, r_den_a, r_num_b, r_den_b;
    t_case                 r_case;
    logic                  par;

    assign da[0] = i_da.x;
    assign da[1] = i_da.y;
    assign da[2] = i_da.z;
    assign db[0] = i_db.x;
    assign db[1] = i_db.y;
    assign db[2] = i_db.z;
    assign w[0]  = i_w.x;
    assign w[1]  = i_w.y;
    assign w[2]  = i_w.z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_aa[k] <= da[k] * da[k];
                r_ee[k] <= db[k] * db[k];
                r_ab[k] <= da[k] * db[k];
                r_aw[k] <= da[k] * w[k];
                r_bw[k] <= db[k] * w[k];
            end
            r_a <= DW'(r_aa[0]) + DW'(r_aa[1]) + DW'(r_aa[2]);
            r_e <= DW'(r_ee[0]) + DW'(r_ee[1]) + DW'(r_ee[2]);
            r_b <= DW'(r_ab[0]) + DW'(r_ab[1]) + DW'(r_ab[2]);
            r_c <= DW'(r_aw[0]) + DW'(r_aw[1]) + DW'(r_aw[2]);
            r_f <= DW'(r_bw[0]) + DW'(r_bw[1]) + DW'(r_bw[2]);
        end
    end

    lcp_wmul u_mul_ae (.i_clk(i_clk), .i_en(i_en), .i_a(r_a), .i_b(r_e), .o_p(p_ae));
    lcp_wmul u_mul_bb (.i_clk(i_clk), .i_en(i_en), .i_a(r_b), .i_b(r_b), .o_p(p_bb));
    lcp_wmul u_mul_bf (.i_clk(i_clk), .i_en(i_en), .i_a(r_b), .i_b(r_f), .o_p(p_bf));
    lcp_wmul u_mul_ec (.i_clk(i_clk), .i_en(i_en), .i_a(r_e), .i_b(r_c), .o_p(p_ec));
    lcp_wmul u_mul_af (.i_clk(i_clk), .i_en(i_en), .i_a(r_a), .i_b(r_f), .o_p(p_af));
    lcp_wmul u_mul_bc (.i_clk(i_clk), .i_en(i_en), .i_a(r_b), .i_b(r_c), .o_p(p_bc));

    // Lines count as parallel when |D| scaled down to the register's format is within it.
    assign par = (r_absd >> (2 * FB)) <= PW'(i_eps);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_dly[0] <= r_e;
            r_f_dly[0] <= r_f;
            for (int k = 1; k < 5; k++) begin
                r_e_dly[k] <= r_e_dly[k-1];
                r_f_dly[k] <= r_f_dly[k-1];
            end
            r_dd   <= p_ae - p_bb;
            r_sn   <= p_bf - p_ec;
            r_tn   <= p_af - p_bc;
            r_absd <= r_dd[PW-1] ? -r_dd : r_dd;
            r_dd7  <= r_dd;
            r_sn7  <= r_sn;
            r_tn7  <= r_tn;
            r_num_a      <= r_sn7;
            r_den_a      <= r_dd7;
            r_num_b      <= par ? PW'(r_f_dly[4]) : r_tn7;
            r_den_b      <= par ? PW'(r_e_dly[4]) : r_dd7;
            r_case.par   <= par;
            r_case.degen <= par && (r_e_dly[4] == '0);
        end
    end

    assign o_num_a = r_num_a;
    assign o_den_a = r_den_a;
    assign o_num_b = r_num_b;
    assign o_den_b = r_den_b;
    assign o_case  = r_case;

endmodule

### hdl/lcp_div.sv
// Scales a numerator by one direction component and divides it, one quotient bit per stage.
module lcp_div import lcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [PW-1:0] i_num,
    input  logic signed [PW-1:0] i_den,
    input  logic signed [CW-1:0] i_dir,
    output logic signed [QW-1:0] o_quo
);

    logic signed [CKW:0]      ck [3];
    logic signed [TW-1:0]     ck_top;
    logic signed [CKW+CW:0]   r_pp [3];
    logic signed [TW+CW-1:0]  r_pp3;
    logic [PW-1:0]            r_ud1, r_ud2, r_ud3, r_ud4;
    logic                     r_dneg1, r_dneg2, r_dneg3;
    logic signed [SW-1:0]     r_s01, r_s23;
    logic signed [MW-1:0]     r_m;
    logic [MW-1:0]            r_un;
    logic                     r_neg4;
    logic [MW-1:0]            r_rem [QB+1];
    logic [QB-1:0]            r_q   [QB+1];
    logic [PW-1:0]            r_udv [QB+1];
    logic                     r_negv [QB+1];
    logic                     r_bigv [QB+1];
    logic                     rnd;
    logic [QB:0]              n_mag;
    logic [QW-1:0]            mag_x;
    logic signed [QW-1:0]     r_quo;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ck[k] = $signed({1'b0, i_num[k*CKW +: CKW]});
        end
        ck_top = i_num[PW-1:3*CKW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pp[k] <= ck[k] * i_dir;
            end
            r_pp3   <= ck_top * i_dir;
            r_ud1   <= i_den[PW-1] ? -i_den : i_den;
            r_dneg1 <= i_den[PW-1];

            r_s01   <= SW'(r_pp[0]) + (SW'(r_pp[1]) <<< CKW);
            r_s23   <= SW'(r_pp[2]) + (SW'(r_pp3) <<< CKW);
            r_ud2   <= r_ud1;
            r_dneg2 <= r_dneg1;

            r_m     <= MW'(r_s01) + (MW'(r_s23) <<< (2 * CKW));
            r_ud3   <= r_ud2;
            r_dneg3 <= r_dneg2;

            r_un    <= r_m[MW-1] ? -r_m : r_m;
            r_neg4  <= r_m[MW-1] ^ r_dneg3;
            r_ud4   <= r_ud3;

            // A quotient this large saturates any coordinate, so the exact bits are not needed.
            r_bigv[0] <= RW'(r_un) >= (RW'(r_ud4) << QB);
            r_rem[0]  <= r_un;
            r_q[0]    <= '0;
            r_udv[0]  <= r_ud4;
            r_negv[0] <= r_neg4;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int BIT = QB - 1 - j;
        logic [RW-1:0] trial;
        logic          ge;
        logic [MW-1:0] n_rem;
        logic [QB-1:0] n_q;

        always_comb begin
            trial = RW'(r_udv[j]) << BIT;
            ge    = RW'(r_rem[j]) >= trial;
            n_rem = ge ? MW'(RW'(r_rem[j]) - trial) : r_rem[j];
            n_q   = r_q[j];
            n_q[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= n_rem;
                r_q[j+1]    <= n_q;
                r_udv[j+1]  <= r_udv[j];
                r_negv[j+1] <= r_negv[j];
                r_bigv[j+1] <= r_bigv[j];
            end
        end
    end

    // Round the magnitude half away from zero, or pin it to 2**QB when it is too large, then apply the sign.
    always_comb begin
        rnd   = (RW'(r_rem[QB]) << 1) >= RW'(r_udv[QB]);
        n_mag = (QB+1)'(r_q[QB]) + (QB+1)'(rnd);
        if (r_bigv[QB]) begin
            n_mag = '0;
            n_mag[QB] = 1'b1;
        end
        mag_x = QW'(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_negv[QB] ? -mag_x : mag_x;
        end
    end

    assign o_quo = r_quo;

endmodule

### hdl/line_line_closest_points.sv
// Top level: closest points between two unbounded 3D lines, fully pipelined.
//
//  Port          Direction  Transaction contents
//  i_query       sink       two lines: origin and direction each, signed Q16.16
//  o_result      source     near point on each line, squared gap, status
//  i_cfg_wr_*    write      parallel_epsilon, 63 bits
//
// One transaction enters per cycle while o_result is not stalled; most of the pipeline depth
// comes from the one-bit-per-stage dividers.
// A stall on o_result freezes every stage at once, so nothing is lost or repeated.
// Reset is synchronous, active low; it clears the valid bits and sets epsilon to 16.
module line_line_closest_points import lcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [EPS_W-1:0] i_cfg_wr_data,
    lcp_in_if.sink           i_query,
    lcp_out_if.source        o_result
);

    localparam int DQ   = COEF_LAT + DIV_LAT;
    localparam int NSTG = DQ + 5;
    localparam int AW   = QW + 1;
    localparam int GSW  = (SQ_W + 2 > GAP_W + 1) ? SQ_W + 2 : GAP_W + 1;

    typedef struct packed {
        t_vec a;
        t_vec b;
    } t_pair;

    typedef struct packed {
        t_vec a;
        t_vec b;
        logic ovf;
        logic par;
        logic degen;
    } t_pt;

    logic                 en;
    logic [EPS_W-1:0]     r_eps;
    logic                 r_vld [NSTG];
    t_pair                r_org0, r_dir0;
    t_wvec                r_w0;
    t_pair                r_dir [COEF_LAT];
    t_pair                r_org [DQ];
    t_case                r_flg [DIV_LAT];
    logic signed [PW-1:0] num_a, den_a, num_b, den_b;
    t_case                coef_case;
    logic signed [QW-1:0] quo_a [3];
    logic signed [QW-1:0] quo_b [3];
    logic signed [CW-1:0] dir_a [3];
    logic signed [CW-1:0] dir_b [3];
    logic signed [CW-1:0] org_a [3];
    logic signed [CW-1:0] org_b [3];
    logic signed [CW-1:0] n_na [3];
    logic signed [CW-1:0] n_nb [3];
    logic                 n_ovf;
    t_pt                  n_pt1;
    t_pt                  r_pt1, r_pt2, r_pt3;
    logic signed [WW-1:0] r_dif [3];
    logic signed [WW-1:0] dif [3];
    logic [SQ_W-1:0]      r_sq [3];
    logic [GSW-1:0]       n_sum;
    logic                 gap_ovf;
    t_status              n_status;
    t_vec                 r_out_a, r_out_b;
    logic [GAP_W-1:0]     r_out_gap;
    t_status              r_out_status;

    function automatic logic [CW:0] sat_add(input logic signed [CW-1:0] org,
                                            input logic signed [QW-1:0] quo);
        logic signed [AW-1:0] sum;
        logic                 fits;
        logic [CW-1:0]        val;
        sum  = AW'(org) + AW'(quo);
        fits = (sum[AW-1:CW-1] == '0) || (sum[AW-1:CW-1] == '1);
        val  = sum[CW-1:0];
        if (!fits) begin
            val = {sum[AW-1], {(CW-1){~sum[AW-1]}}};
        end
        return {~fits, val};
    endfunction

    assign en = !r_vld[NSTG-1] || o_result.ready;
    assign i_query.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(16);
        end else if (i_cfg_wr_en) begin
            r_eps <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_query.valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_org0.a.x <= i_query.origin_a_x;
            r_org0.a.y <= i_query.origin_a_y;
            r_org0.a.z <= i_query.origin_a_z;
            r_org0.b.x <= i_query.origin_b_x;
            r_org0.b.y <= i_query.origin_b_y;
            r_org0.b.z <= i_query.origin_b_z;
            r_dir0.a.x <= i_query.dir_a_x;
            r_dir0.a.y <= i_query.dir_a_y;
            r_dir0.a.z <= i_query.dir_a_z;
            r_dir0.b.x <= i_query.dir_b_x;
            r_dir0.b.y <= i_query.dir_b_y;
            r_dir0.b.z <= i_query.dir_b_z;
            r_w0.x <= WW'(i_query.origin_a_x) - WW'(i_query.origin_b_x);
            r_w0.y <= WW'(i_query.origin_a_y) - WW'(i_query.origin_b_y);
            r_w0.z <= WW'(i_query.origin_a_z) - WW'(i_query.origin_b_z);

            r_dir[0] <= r_dir0;
            for (int k = 1; k < COEF_LAT; k++) begin
                r_dir[k] <= r_dir[k-1];
            end
            r_org[0] <= r_org0;
            for (int k = 1; k < DQ; k++) begin
                r_org[k] <= r_org[k-1];
            end
            r_flg[0] <= coef_case;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    lcp_coef u_coef (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_eps   (r_eps),
        .i_da    (r_dir0.a),
        .i_db    (r_dir0.b),
        .i_w     (r_w0),
        .o_num_a (num_a),
        .o_den_a (den_a),
        .o_num_b (num_b),
        .o_den_b (den_b),
        .o_case  (coef_case)
    );

    assign dir_a[0] = r_dir[COEF_LAT-1].a.x;
    assign dir_a[1] = r_dir[COEF_LAT-1].a.y;
    assign dir_a[2] = r_dir[COEF_LAT-1].a.z;
    assign dir_b[0] = r_dir[COEF_LAT-1].b.x;
    assign dir_b[1] = r_dir[COEF_LAT-1].b.y;
    assign dir_b[2] = r_dir[COEF_LAT-1].b.z;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        lcp_div u_div_a (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num_a),
            .i_den (den_a),
            .i_dir (dir_a[k]),
            .o_quo (quo_a[k])
        );
        lcp_div u_div_b (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num_b),
            .i_den (den_b),
            .i_dir (dir_b[k]),
            .o_quo (quo_b[k])
        );
    end

    assign org_a[0] = r_org[DQ-1].a.x;
    assign org_a[1] = r_org[DQ-1].a.y;
    assign org_a[2] = r_org[DQ-1].a.z;
    assign org_b[0] = r_org[DQ-1].b.x;
    assign org_b[1] = r_org[DQ-1].b.y;
    assign org_b[2] = r_org[DQ-1].b.z;

    // Parallel lines keep origin A; a zero second direction keeps origin B as well.
    always_comb begin
        logic [CW:0] sa;
        logic [CW:0] sb;
        n_ovf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            sa = sat_add(org_a[k], quo_a[k]);
            sb = sat_add(org_b[k], quo_b[k]);
            n_na[k] = r_flg[DIV_LAT-1].par ? org_a[k] : sa[CW-1:0];
            n_nb[k] = r_flg[DIV_LAT-1].degen ? org_b[k] : sb[CW-1:0];
            n_ovf = n_ovf | (sa[CW] & ~r_flg[DIV_LAT-1].par)
                          | (sb[CW] & ~r_flg[DIV_LAT-1].degen);
        end
        n_pt1.a.x   = n_na[0];
        n_pt1.a.y   = n_na[1];
        n_pt1.a.z   = n_na[2];
        n_pt1.b.x   = n_nb[0];
        n_pt1.b.y   = n_nb[1];
        n_pt1.b.z   = n_nb[2];
        n_pt1.ovf   = n_ovf;
        n_pt1.par   = r_flg[DIV_LAT-1].par;
        n_pt1.degen = r_flg[DIV_LAT-1].degen;
    end

    assign dif[0] = WW'(r_pt1.a.x) - WW'(r_pt1.b.x);
    assign dif[1] = WW'(r_pt1.a.y) - WW'(r_pt1.b.y);
    assign dif[2] = WW'(r_pt1.a.z) - WW'(r_pt1.b.z);

    always_comb begin
        n_sum = GSW'(r_sq[0]) + GSW'(r_sq[1]) + GSW'(r_sq[2]);
        gap_ovf = |n_sum[GSW-1:GAP_W];
        if (r_pt3.ovf || gap_ovf) begin
            n_status = ST_OVERFLOW;
        end else if (r_pt3.degen) begin
            n_status = ST_DEGEN;
        end else if (r_pt3.par) begin
            n_status = ST_PARALLEL;
        end else begin
            n_status = ST_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt1 <= n_pt1;
            for (int k = 0; k < 3; k++) begin
                r_dif[k] <= dif[k];
                r_sq[k]  <= SQ_W'(r_dif[k] * r_dif[k]);
            end
            r_pt2 <= r_pt1;
            r_pt3 <= r_pt2;
            r_out_a      <= r_pt3.a;
            r_out_b      <= r_pt3.b;
            r_out_gap    <= gap_ovf ? '1 : n_sum[GAP_W-1:0];
            r_out_status <= n_status;
        end
    end

    assign o_result.valid       = r_vld[NSTG-1];
    assign o_result.near_a_x    = r_out_a.x;
    assign o_result.near_a_y    = r_out_a.y;
    assign o_result.near_a_z    = r_out_a.z;
    assign o_result.near_b_x    = r_out_b.x;
    assign o_result.near_b_y    = r_out_b.y;
    assign o_result.near_b_z    = r_out_b.z;
    assign o_result.gap_squared = r_out_gap;
    assign o_result.status      = r_out_status;

endmodule
